/* hdl/utf8tlf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package utf8tlf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned IndexW = 5;
  localparam int unsigned PendW  = 2;

  // pending continuation counts
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  // whitespace codes
  localparam logic [CodeW-1:0] CodeTab   = 21'h09;
  localparam logic [CodeW-1:0] CodeLf    = 21'h0A;
  localparam logic [CodeW-1:0] CodeVt    = 21'h0B;
  localparam logic [CodeW-1:0] CodeFf    = 21'h0C;
  localparam logic [CodeW-1:0] CodeCr    = 21'h0D;
  localparam logic [CodeW-1:0] CodeSpace = 21'h20;

  // letter ranges
  localparam logic [CodeW-1:0] CodeUpperA = 21'h41;
  localparam logic [CodeW-1:0] CodeUpperZ = 21'h5A;
  localparam logic [CodeW-1:0] CodeLowerA = 21'h61;
  localparam logic [CodeW-1:0] CodeLowerZ = 21'h7A;

  typedef struct packed {
    logic             done;
    logic [CodeW-1:0] cp;
  } dec_res_t;

  function automatic logic is_space(input logic [CodeW-1:0] cp);
    is_space = (cp == CodeSpace) || (cp == CodeTab) || (cp == CodeLf) ||
               (cp == CodeVt) || (cp == CodeFf) || (cp == CodeCr);
  endfunction

  function automatic logic is_letter(input logic [CodeW-1:0] cp);
    is_letter = ((cp >= CodeUpperA) && (cp <= CodeUpperZ)) ||
                ((cp >= CodeLowerA) && (cp <= CodeLowerZ));
  endfunction

endpackage
`default_nettype wire

/* hdl/utf8tlf_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
module utf8tlf_decode (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [utf8tlf_pkg::ByteW-1:0]    byte_in,
  input  wire logic                             eot,
  output utf8tlf_pkg::dec_res_t                 res
);

  logic [utf8tlf_pkg::CodeW-1:0] partial_r, partial_nxt;
  logic [utf8tlf_pkg::PendW-1:0] pend_r, pend_nxt;
  logic [utf8tlf_pkg::CodeW-1:0] shifted;

  assign shifted = {partial_r[utf8tlf_pkg::CodeW-7:0], byte_in[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    res.done    = 1'b0;
    res.cp      = '0;
    if ((pend_r != utf8tlf_pkg::PendNone) && (byte_in[7:6] == 2'b10)) begin
      // continuation byte
      partial_nxt = shifted;
      pend_nxt    = pend_r - utf8tlf_pkg::PendOne;
      if (pend_r == utf8tlf_pkg::PendOne) begin
        res.done = 1'b1;
        res.cp   = shifted;
      end
    end else begin
      // lead byte, dropping any partial sequence
      pend_nxt = utf8tlf_pkg::PendNone;
      if (byte_in[7] == 1'b0) begin
        res.done = 1'b1;
        res.cp   = {{(utf8tlf_pkg::CodeW-utf8tlf_pkg::ByteW){1'b0}}, byte_in};
      end else if (byte_in[7:5] == 3'b110) begin
        partial_nxt = {{(utf8tlf_pkg::CodeW-5){1'b0}}, byte_in[4:0]};
        pend_nxt    = utf8tlf_pkg::PendOne;
      end else if (byte_in[7:4] == 4'b1110) begin
        partial_nxt = {{(utf8tlf_pkg::CodeW-4){1'b0}}, byte_in[3:0]};
        pend_nxt    = utf8tlf_pkg::PendTwo;
      end else if (byte_in[7:3] == 5'b11110) begin
        partial_nxt = {{(utf8tlf_pkg::CodeW-3){1'b0}}, byte_in[2:0]};
        pend_nxt    = utf8tlf_pkg::PendThree;
      end
    end
    if (eot) begin
      partial_nxt = '0;
      pend_nxt    = utf8tlf_pkg::PendNone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pend_r    <= utf8tlf_pkg::PendNone;
    end else if (step) begin
      partial_r <= partial_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/utf8_text_letter_filter.sv */
// an accepted byte is held in the input stage; its result is registered at the output
// throughput: one byte per cycle, sustained while the result side keeps taking
// the output register decouples: while a result waits, an empty input stage takes a byte
// reset (rst_n, synchronous, active low) empties both stages and clears the
// partial code point and the pending continuation count
`timescale 1ns / 1ps
`default_nettype none
module utf8_text_letter_filter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [utf8tlf_pkg::ByteW-1:0]      in_byte,
  input  wire logic                               in_end_of_text,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [utf8tlf_pkg::CodeW-1:0]      out_code_point,
  output      logic                               out_is_ascii_letter,
  output      logic [utf8tlf_pkg::IndexW-1:0]     out_letter_index
);

  // input stage: one request held for the decoder
  logic                          s1_valid_r;
  logic [utf8tlf_pkg::ByteW-1:0] s1_byte_r;
  logic                          s1_eot_r;

  // result register
  logic                           out_valid_r;
  logic [utf8tlf_pkg::CodeW-1:0]  code_r;
  logic                           letter_r;
  logic [utf8tlf_pkg::IndexW-1:0] index_r;

  logic                  step;
  logic                  emit;
  logic                  letter;
  utf8tlf_pkg::dec_res_t dec;

  // the decoder steps when the result register is free or being drained
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  utf8tlf_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (s1_byte_r),
    .eot     (s1_eot_r),
    .res     (dec)
  );

  // whitespace is swallowed; everything else completed goes out
  assign emit   = dec.done && !utf8tlf_pkg::is_space(dec.cp);
  assign letter = utf8tlf_pkg::is_letter(dec.cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // letters a-z and A-Z share the low five bits, offset by one
  always_ff @(posedge clk) begin
    if (step && emit) begin
      code_r   <= dec.cp;
      letter_r <= letter;
      index_r  <= letter ? (dec.cp[utf8tlf_pkg::IndexW-1:0] - 5'd1) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_code_point      = code_r;
  assign out_is_ascii_letter = letter_r;
  assign out_letter_index    = index_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import utf8tlf_pkg::*;

  // byte classes: mask and tag of the high bits
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;

  localparam int RandomItems = 1450;
  localparam int HoldCycles  = 200;   // long receiver hold-off
  localparam int StallLimit  = 2000;  // cycles with no request moving on either side
  localparam int CalmTail    = 150;   // last requests go through with no idling

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eot;
  } text_req_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic              letter;
    logic [IndexW-1:0] index;
  } glyph_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ByteW-1:0]  in_byte = '0;
  logic              in_end_of_text = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CodeW-1:0]  out_code_point;
  logic              out_is_ascii_letter;
  logic [IndexW-1:0] out_letter_index;

  utf8_text_letter_filter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_code_point      (out_code_point),
    .out_is_ascii_letter (out_is_ascii_letter),
    .out_letter_index    (out_letter_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // text still to send, and glyphs the decoder owes us
  text_req_t text_q[$];
  glyph_t    glyphs_due[$];

  // decoder state mirrored on our side
  logic [CodeW-1:0] cp_acc = '0;
  logic [PendW-1:0] cont_left = PendNone;

  int n_total = 0;
  int n_taken = 0;       // updated with nonblocking assignment, so every block sees the same value
  int n_errors = 0;
  int idle_cycles = 0;

  // decode one accepted byte and queue the glyph it completes, if any
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eot);
    logic [CodeW-1:0] cp;
    logic             done;
    glyph_t           g;
    cp = '0;
    done = 1'b0;
    if (cont_left != PendNone && (b & ContMask) == ContTag) begin
      cp_acc = {cp_acc[CodeW-7:0], b[5:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == PendNone) begin
        cp = cp_acc;
        done = 1'b1;
      end
    end else begin
      // a non-continuation byte drops any unfinished sequence and starts afresh
      cont_left = PendNone;
      if (!b[7]) begin
        cp = CodeW'(b);
        done = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        cp_acc = CodeW'(b[4:0]);
        cont_left = PendOne;
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        cp_acc = CodeW'(b[3:0]);
        cont_left = PendTwo;
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        cp_acc = CodeW'(b[2:0]);
        cont_left = PendThree;
      end
      // stray continuation and 11111xxx leads fall through untouched
    end
    if (done && !(cp == CodeSpace || cp == CodeTab || cp == CodeLf ||
                  cp == CodeVt || cp == CodeFf || cp == CodeCr)) begin
      g.code = cp;
      g.letter = 1'b0;
      g.index = '0;
      if (cp >= CodeUpperA && cp <= CodeUpperZ) begin
        g.letter = 1'b1;
        g.index = IndexW'(cp - CodeUpperA);
      end else if (cp >= CodeLowerA && cp <= CodeLowerZ) begin
        g.letter = 1'b1;
        g.index = IndexW'(cp - CodeLowerA);
      end
      glyphs_due.push_back(g);
    end
    if (eot) begin
      cp_acc = '0;
      cont_left = PendNone;
    end
  endtask

  task automatic add_req(input logic [ByteW-1:0] b, input logic eot = 1'b0);
    text_req_t r;
    r.data = b;
    r.eot = eot;
    text_q.push_back(r);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    return ContTag | (ByteW'($urandom) & ~ContMask);
  endfunction

  // one random run: mostly well-formed sequences, some cut short, some noise
  task automatic add_random_run();
    logic [ByteW-1:0] seq[4];
    logic [CodeW-1:0] ws[6];
    int kind, len, keep;
    ws = '{CodeSpace, CodeTab, CodeLf, CodeVt, CodeFf, CodeCr};
    kind = $urandom_range(0, 99);
    len = $urandom_range(1, 4);
    case (len)
      1: begin
        case ($urandom_range(0, 3))
          0, 1: seq[0] = ByteW'($urandom_range(0, 127));
          2: seq[0] = ByteW'($urandom_range(0, 1) ? $urandom_range(8'h41, 8'h5A)
                                                  : $urandom_range(8'h61, 8'h7A));
          default: seq[0] = ByteW'(ws[$urandom_range(0, 5)]);
        endcase
      end
      2: seq[0] = Lead2Tag | (ByteW'($urandom) & ~Lead2Mask);
      3: seq[0] = Lead3Tag | (ByteW'($urandom) & ~Lead3Mask);
      default: seq[0] = Lead4Tag | (ByteW'($urandom) & ~Lead4Mask);
    endcase
    for (int i = 1; i < 4; i++) seq[i] = cont_byte();
    if (kind < 72) begin
      keep = len;
    end else if (kind < 86 && len > 1) begin
      keep = $urandom_range(1, len - 1);   // cut short; the next run's first byte normally interrupts it
    end else begin
      seq[0] = ByteW'($urandom_range(0, 255));
      keep = 1;
    end
    for (int i = 0; i < keep; i++)
      add_req(seq[i], (i == keep - 1) && ($urandom_range(0, 29) == 0));
  endtask

  // driver: offers the text one request at a time, with random gap bursts
  int gap_left = 0;
  always @(posedge clk) begin
    text_req_t r;
    logic      nxt_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, in_end_of_text);
        n_taken <= n_taken + 1;
      end
      // hold the request steady until it has been taken
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_q.size() > 0) begin
          if (n_taken + CalmTail < n_total && $urandom_range(0, 19) == 0) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            r = text_q.pop_front();
            in_byte <= r.data;
            in_end_of_text <= r.eot;
            nxt_valid = 1'b1;
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // monitor: compares each glyph with the oldest one owed, stalls at random
  int  hold_left = 0;
  bit  held_long = 1'b0;
  always @(posedge clk) begin
    glyph_t g;
    logic   nxt_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (glyphs_due.size() == 0) begin
          $error("unexpected glyph: code_point %0h", out_code_point);
          n_errors++;
        end else begin
          g = glyphs_due.pop_front();
          if (out_code_point !== g.code) begin
            $error("code_point: expected %0h, got %0h", g.code, out_code_point);
            n_errors++;
          end
          if (out_is_ascii_letter !== g.letter) begin
            $error("is_ascii_letter: expected %0d, got %0d", g.letter, out_is_ascii_letter);
            n_errors++;
          end
          if (out_letter_index !== g.index) begin
            $error("letter_index: expected %0d, got %0d", g.index, out_letter_index);
            n_errors++;
          end
        end
      end
      nxt_ready = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_long && n_taken >= 300) begin
        // long hold-off: the decoder must fill up and push back on its input
        held_long = 1'b1;
        hold_left = HoldCycles - 1;
      end else if (n_taken + CalmTail < n_total && $urandom_range(0, 19) == 0) begin
        hold_left = $urandom_range(1, 15) - 1;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // cycles in which no request moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // letters at the ends of both ranges and their neighbours
    add_req(8'h41); add_req(8'h5A); add_req(8'h61); add_req(8'h7A);
    add_req(8'h5B); add_req(8'h7B); add_req(8'h00); add_req(8'h7F);
    // every whitespace code is dropped
    add_req(8'h20); add_req(8'h09); add_req(8'h0A);
    add_req(8'h0B); add_req(8'h0C); add_req(8'h0D);
    // two, three and four byte sequences, the last one the largest 21-bit value
    add_req(8'hC2); add_req(8'hA9);
    add_req(8'hE2); add_req(8'h82); add_req(8'hAC);
    add_req(8'hF7); add_req(8'hBF); add_req(8'hBF); add_req(8'hBF);
    // sequence interrupted by an ascii lead
    add_req(8'hE2); add_req(8'h41);
    // stray continuation, invalid leads
    add_req(8'h80); add_req(8'hF8); add_req(8'hFF);
    // end of text mid-sequence, so the continuation that follows is stray
    add_req(8'hC3, 1'b1); add_req(8'hA9);
    while (text_q.size() < 30 + RandomItems) add_random_run();
    n_total = text_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total) @(posedge clk);
    while (glyphs_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (glyphs_due.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
